@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define TSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define TSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/tsd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsd_pkg
// Types and constants shared by the radial dead-zone pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package tsd_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int SQRT_STEPS   = SAMPLE_WIDTH;
	localparam int DIV_STEPS    = SAMPLE_WIDTH;

	localparam logic [14:0] FULL_SCALE = 15'h7FFF;
	localparam logic [14:0] DZ_RESET   = 15'd7849;

	// multiples of full scale for the constant division correction
	localparam logic [16:0] FS_X1 = 17'd32767;
	localparam logic [16:0] FS_X2 = 17'd65534;
	localparam logic [16:0] FS_X3 = 17'd98301;

	// per-item sideband that rides along the arithmetic stages
	typedef struct packed {
		logic        neg_x;
		logic        neg_y;
		logic [15:0] ax;
		logic [15:0] ay;
		logic        zero;
	} side_t;

endpackage
`default_nettype wire

@@ rtl/tsd_sqrt.sv @@
// ----------------------------------------------------------------------------
// tsd_sqrt
// Pipelined integer square root, two radicand bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tsd_sqrt (
	input  wire logic                          clk,
	input  wire logic [tsd_pkg::SQRT_STEPS-1:0] en,
	input  wire logic [31:0]                   rad,
	input  wire tsd_pkg::side_t                side_i,
	output logic [15:0]                        root,
	output tsd_pkg::side_t                     side_o
);

	logic [17:0]    rem_s  [tsd_pkg::SQRT_STEPS];
	logic [15:0]    root_s [tsd_pkg::SQRT_STEPS];
	logic [31:0]    rad_s  [tsd_pkg::SQRT_STEPS];
	tsd_pkg::side_t side_s [tsd_pkg::SQRT_STEPS];

	logic [17:0]    rem_n  [tsd_pkg::SQRT_STEPS];
	logic [15:0]    root_n [tsd_pkg::SQRT_STEPS];
	logic [31:0]    rad_n  [tsd_pkg::SQRT_STEPS];
	tsd_pkg::side_t side_n [tsd_pkg::SQRT_STEPS];

	// one restoring root step per stage
	always_comb begin
		logic [17:0]    rem_p;
		logic [15:0]    root_p;
		logic [31:0]    rad_p;
		logic [19:0]    rem2;
		logic [19:0]    trial;
		logic           ge;
		for (int g = 0; g < tsd_pkg::SQRT_STEPS; g++) begin
			if (g == 0) begin
				rem_p     = '0;
				root_p    = '0;
				rad_p     = rad;
				side_n[g] = side_i;
			end else begin
				rem_p     = rem_s[g-1];
				root_p    = root_s[g-1];
				rad_p     = rad_s[g-1];
				side_n[g] = side_s[g-1];
			end
			rem2      = {rem_p, rad_p[31:30]};
			trial     = {2'b00, root_p, 2'b01};
			ge        = (rem2 >= trial);
			rem_n[g]  = ge ? 18'(rem2 - trial) : rem2[17:0];
			root_n[g] = {root_p[14:0], ge};
			rad_n[g]  = {rad_p[29:0], 2'b00};
		end
	end

	// advance each stage when it is allowed to load
	always_ff @(posedge clk) begin
		for (int g = 0; g < tsd_pkg::SQRT_STEPS; g++) begin
			if (en[g]) begin
				rem_s[g]  <= rem_n[g];
				root_s[g] <= root_n[g];
				rad_s[g]  <= rad_n[g];
				side_s[g] <= side_n[g];
			end
		end
	end

	assign root   = root_s[tsd_pkg::SQRT_STEPS-1];
	assign side_o = side_s[tsd_pkg::SQRT_STEPS-1];

endmodule
`default_nettype wire

@@ rtl/tsd_div.sv @@
// ----------------------------------------------------------------------------
// tsd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tsd_div (
	input  wire logic                         clk,
	input  wire logic [tsd_pkg::DIV_STEPS-1:0] en,
	input  wire logic [14:0]                  rem0,
	input  wire logic [15:0]                  lo,
	input  wire logic [14:0]                  dv,
	input  wire tsd_pkg::side_t               side_i,
	output logic [15:0]                       quo,
	output tsd_pkg::side_t                    side_o
);

	logic [14:0]    rem_s  [tsd_pkg::DIV_STEPS];
	logic [15:0]    lo_s   [tsd_pkg::DIV_STEPS];
	logic [14:0]    dv_s   [tsd_pkg::DIV_STEPS];
	logic [15:0]    quo_s  [tsd_pkg::DIV_STEPS];
	tsd_pkg::side_t side_s [tsd_pkg::DIV_STEPS];

	logic [14:0]    rem_n  [tsd_pkg::DIV_STEPS];
	logic [15:0]    lo_n   [tsd_pkg::DIV_STEPS];
	logic [14:0]    dv_n   [tsd_pkg::DIV_STEPS];
	logic [15:0]    quo_n  [tsd_pkg::DIV_STEPS];
	tsd_pkg::side_t side_n [tsd_pkg::DIV_STEPS];

	// shift in one dividend bit, subtract when it fits
	always_comb begin
		logic [14:0] rem_p;
		logic [15:0] lo_p;
		logic [15:0] quo_p;
		logic [15:0] rem2;
		logic        ge;
		for (int g = 0; g < tsd_pkg::DIV_STEPS; g++) begin
			if (g == 0) begin
				rem_p     = rem0;
				lo_p      = lo;
				quo_p     = '0;
				dv_n[g]   = dv;
				side_n[g] = side_i;
			end else begin
				rem_p     = rem_s[g-1];
				lo_p      = lo_s[g-1];
				quo_p     = quo_s[g-1];
				dv_n[g]   = dv_s[g-1];
				side_n[g] = side_s[g-1];
			end
			rem2     = {rem_p, lo_p[15]};
			ge       = (rem2 >= {1'b0, dv_n[g]});
			rem_n[g] = ge ? 15'(rem2 - {1'b0, dv_n[g]}) : rem2[14:0];
			quo_n[g] = {quo_p[14:0], ge};
			lo_n[g]  = {lo_p[14:0], 1'b0};
		end
	end

	// advance each stage when it is allowed to load
	always_ff @(posedge clk) begin
		for (int g = 0; g < tsd_pkg::DIV_STEPS; g++) begin
			if (en[g]) begin
				rem_s[g]  <= rem_n[g];
				lo_s[g]   <= lo_n[g];
				dv_s[g]   <= dv_n[g];
				quo_s[g]  <= quo_n[g];
				side_s[g] <= side_n[g];
			end
		end
	end

	assign quo    = quo_s[tsd_pkg::DIV_STEPS-1];
	assign side_o = side_s[tsd_pkg::DIV_STEPS-1];

endmodule
`default_nettype wire

@@ rtl/thumbstick_radial_deadzone.sv @@
// ----------------------------------------------------------------------------
// thumbstick_radial_deadzone
// Radial dead zone with rescaling for a two-axis stick, signed Q1.15 out.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; a full stage holds only while the next cannot load.
// Stages: abs, square, sum, 16 root steps, clamp, 16 divide steps, scale,
// divide by full scale, saturate.
// Reset clears all stage valid bits and loads dead_zone with 7849.
`default_nettype none
`include "assert_macros.svh"
module thumbstick_radial_deadzone (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [14:0] cfg_data,   // dead_zone
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,    // [15:0] stick_x, [31:16] stick_y
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata     // [15:0] out_x, [31:16] out_y
);

	localparam int NST   = 39;
	localparam int SQ_LO = 4;
	localparam int DV_LO = 21;

	logic [14:0] dz_q;
	logic [29:0] dz_sq_q;

	logic [NST:1]   vld;
	logic [NST+1:1] rdy;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q <= tsd_pkg::DZ_RESET;
		end else if (cfg_valid) begin
			dz_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		dz_sq_q <= dz_q * dz_q;
	end

	// stage loads when empty or when its word moves on
	always_comb begin
		rdy[NST+1] = m_tready;
		for (int k = NST; k >= 1; k--) begin
			rdy[k] = !vld[k] || rdy[k+1];
		end
	end
	assign s_tready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			if (rdy[1]) begin
				vld[1] <= s_tvalid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (rdy[k]) begin
					vld[k] <= vld[k-1];
				end
			end
		end
	end

	// stage 1: magnitudes and signs
	tsd_pkg::side_t side_s1;
	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			side_s1.neg_x <= s_tdata[15];
			side_s1.neg_y <= s_tdata[31];
			side_s1.ax    <= s_tdata[15] ? 16'(~s_tdata[15:0] + 16'd1) : s_tdata[15:0];
			side_s1.ay    <= s_tdata[31] ? 16'(~s_tdata[31:16] + 16'd1) : s_tdata[31:16];
			side_s1.zero  <= 1'b0;
		end
	end

	// stage 2: squares
	tsd_pkg::side_t side_s2;
	logic [31:0]    sqx_s2, sqy_s2;
	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			side_s2 <= side_s1;
			sqx_s2  <= side_s1.ax * side_s1.ax;
			sqy_s2  <= side_s1.ay * side_s1.ay;
		end
	end

	// stage 3: squared radius and dead-zone test
	tsd_pkg::side_t side_s3;
	tsd_pkg::side_t side_c3;
	logic [31:0]    sum_s3;
	logic [31:0]    sum_c;
	assign sum_c = sqx_s2 + sqy_s2;
	always_comb begin
		side_c3      = side_s2;
		side_c3.zero = (sum_c <= {2'b00, dz_sq_q}) || (dz_q == tsd_pkg::FULL_SCALE);
	end
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			side_s3 <= side_c3;
			sum_s3  <= sum_c;
		end
	end

	// stages 4..19: square root
	logic [15:0]    root;
	tsd_pkg::side_t side_sq;
	tsd_sqrt u_sqrt (
		.clk    (clk),
		.en     (rdy[SQ_LO+tsd_pkg::SQRT_STEPS-1:SQ_LO]),
		.rad    (sum_s3),
		.side_i (side_s3),
		.root   (root),
		.side_o (side_sq)
	);

	// stage 20: clamp, compare, set up division
	tsd_pkg::side_t side_s20;
	tsd_pkg::side_t side_c20;
	logic [14:0]    rem0_s20, dv_s20;
	logic [15:0]    lo_s20;
	logic [14:0]    mag_c, diff_c;
	assign mag_c  = root[15] ? tsd_pkg::FULL_SCALE : root[14:0];
	assign diff_c = mag_c - dz_q;
	always_comb begin
		side_c20      = side_sq;
		side_c20.zero = side_sq.zero || (mag_c <= dz_q);
	end
	always_ff @(posedge clk) begin
		if (rdy[20]) begin
			side_s20 <= side_c20;
			rem0_s20 <= {1'b0, diff_c[14:1]};
			lo_s20   <= {diff_c[0], 15'd0};
			dv_s20   <= tsd_pkg::FULL_SCALE - dz_q;
		end
	end

	// stages 21..36: scale division
	logic [15:0]    quo;
	tsd_pkg::side_t side_dv;
	tsd_div u_div (
		.clk    (clk),
		.en     (rdy[DV_LO+tsd_pkg::DIV_STEPS-1:DV_LO]),
		.rem0   (rem0_s20),
		.lo     (lo_s20),
		.dv     (dv_s20),
		.side_i (side_s20),
		.quo    (quo),
		.side_o (side_dv)
	);

	// stage 37: apply scale to each axis
	tsd_pkg::side_t side_s37;
	logic [31:0]    px_s37, py_s37;
	logic [15:0]    scale_c;
	assign scale_c = side_dv.zero ? 16'd0 : quo;
	always_ff @(posedge clk) begin
		if (rdy[37]) begin
			side_s37 <= side_dv;
			px_s37   <= side_dv.ax * scale_c;
			py_s37   <= side_dv.ay * scale_c;
		end
	end

	// floor(p / 32767) via p >> 15 plus correction
	function automatic logic [16:0] div_fs(input logic [31:0] p);
		logic [16:0] t;
		logic [16:0] r;
		t = p[31:15];
		r = {2'b00, p[14:0]} + t;
		return t + 17'(r >= tsd_pkg::FS_X1) + 17'(r >= tsd_pkg::FS_X2)
			+ 17'(r >= tsd_pkg::FS_X3);
	endfunction

	// stage 38: divide by full scale
	tsd_pkg::side_t side_s38;
	logic [16:0]    qx_s38, qy_s38;
	always_ff @(posedge clk) begin
		if (rdy[38]) begin
			side_s38 <= side_s37;
			qx_s38   <= div_fs(px_s37);
			qy_s38   <= div_fs(py_s37);
		end
	end

	// saturate and restore sign
	function automatic logic [15:0] sat_sign(input logic neg, input logic [16:0] q);
		logic [15:0] v;
		if (neg) begin
			v = (q > 17'd32768) ? 16'h8000 : 16'(~q + 17'd1);
		end else begin
			v = (q > 17'd32767) ? 16'h7FFF : q[15:0];
		end
		return v;
	endfunction

	// stage 39: output register
	logic        zero_s39, neg_x_s39;
	logic [31:0] data_s39;
	always_ff @(posedge clk) begin
		if (rdy[39]) begin
			zero_s39  <= side_s38.zero;
			neg_x_s39 <= side_s38.neg_x;
			data_s39  <= {sat_sign(side_s38.neg_y, qy_s38), sat_sign(side_s38.neg_x, qx_s38)};
		end
	end

	assign m_tvalid = vld[NST];
	assign m_tdata  = data_s39;

	`TSD_ASSERT_IMP(a_zero_out, m_tvalid && zero_s39, m_tdata == 32'd0)
	`TSD_ASSERT_IMP(a_sign_x, m_tvalid && m_tdata[15], neg_x_s39)
	`TSD_ASSERT_IMP(a_ready_empty, !m_tvalid, s_tready)

endmodule
`default_nettype wire

@@ bench/thumbstick_radial_deadzone_test.sv @@
// ----------------------------------------------------------------------------
// thumbstick_radial_deadzone_test
// Self-checking bench: directed and random stick samples stream through the
// dead-zone pipeline under random stalls; each output word is checked against a
// local model of the radius, rescale and saturation arithmetic.
// ----------------------------------------------------------------------------
module thumbstick_radial_deadzone_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY    = 39;
	localparam int WDOG_LIMIT = 20000;
	localparam longint FULL   = 32767;

	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
	} stick_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [14:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // [15:0] stick_x, [31:16] stick_y
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;    // [15:0] out_x, [31:16] out_y

	thumbstick_radial_deadzone DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	stick_t      sample_q[$];
	logic [31:0] corrected_q[$];
	logic [14:0] dead_zone;
	int          mismatches;
	int          idle_cycles;
	int          hold_off;
	bit          timed_out;
	bit          draining;

	// floor square root, bit by bit
	function automatic longint floor_root(longint n);
		longint root;
		longint bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n = n - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [15:0] scaled_axis(longint axis, longint scale);
		longint q;
		q = ((axis < 0 ? -axis : axis) * scale) / FULL;
		if (axis < 0) begin
			if (q > 32768) q = 32768;
			return 16'(-q);
		end
		if (q > 32767) q = 32767;
		return 16'(q);
	endfunction

	function automatic logic [31:0] corrected_pair(stick_t s, logic [14:0] dz_reg);
		longint x, y, sum, dz, mag, scale;
		x = s.x;
		y = s.y;
		dz = dz_reg;
		sum = x * x + y * y;
		if (sum <= dz * dz || dz >= FULL) return 32'd0;
		mag = floor_root(sum);
		if (mag > FULL) mag = FULL;
		if (mag <= dz) return 32'd0;
		scale = ((mag - dz) << 15) / (FULL - dz);
		return {scaled_axis(y, scale), scaled_axis(x, scale)};
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drive input words from the pending queue, with random gaps
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) void'(sample_q.pop_front());
			if (send_gap > 0 && !(s_tvalid && !s_tready)) send_gap--;
			if (s_tvalid && !s_tready) begin
				// hold the offered word
			end else if (send_gap == 0 && sample_q.size() > 0 &&
			    !(s_tvalid && s_tready && sample_q.size() == 0)) begin
				s_tvalid <= 1'b1;
				s_tdata  <= sample_q[0];
				send_gap = gap_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// predict on accepted input words
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			corrected_q.push_back(corrected_pair(stick_t'(s_tdata), dead_zone));
	end

	// receiver stalls, plus a long forced hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= draining ? 1'b1 : (gap_len() == 0);
		end
	end

	// compare output words with the oldest prediction
	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (corrected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", m_tdata);
			end else begin
				want = corrected_q.pop_front();
				if (want[15:0] !== m_tdata[15:0] || want[31:16] !== m_tdata[31:16]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: out_x exp %0d got %0d, out_y exp %0d got %0d",
							$signed(want[15:0]), $signed(m_tdata[15:0]),
							$signed(want[31:16]), $signed(m_tdata[31:16]));
				end
			end
		end
	end

	// watchdog on cycles with no accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic wait_drained();
		while (sample_q.size() > 0 || s_tvalid || corrected_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_dead_zone(logic [14:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		dead_zone = value;
		cfg_valid <= 1'b0;
	endtask

	function automatic stick_t rand_stick(int dz);
		stick_t s;
		int r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			// near the dead-zone radius, close to the x or the y axis
			s.x = 16'(dz + $signed($urandom_range(0, 6)) - 3);
			s.y = (r == 0) ? 16'(0) : 16'($urandom_range(0, 4));
			if ($urandom_range(0, 1)) s.x = -s.x;
			if ($urandom_range(0, 1)) begin
				s.y = s.x;
				s.x = 16'($urandom_range(0, 4));
			end
		end else if (r < 3) begin
			s.x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			s.y = 16'($urandom);
		end else begin
			s.x = 16'($urandom);
			s.y = 16'($urandom);
		end
		return s;
	endfunction

	task automatic add_random(int count);
		repeat (count) sample_q.push_back(rand_stick(dead_zone));
	endtask

	initial begin
		logic [14:0] settings[6];
		stick_t      d;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		dead_zone = 15'd7849;
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 0;
		draining = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset dead zone
		d.x = 16'sh7FFF; d.y = 0;       sample_q.push_back(d);
		d.x = 16'sh8000; d.y = 0;       sample_q.push_back(d);
		d.x = 16'sh8000; d.y = 16'sh8000; sample_q.push_back(d);
		d.x = 16'sh7FFF; d.y = 16'sh7FFF; sample_q.push_back(d);
		d.x = 0;         d.y = 0;       sample_q.push_back(d);
		d.x = 7849;      d.y = 0;       sample_q.push_back(d);
		d.x = 7850;      d.y = 0;       sample_q.push_back(d);
		d.x = 0;         d.y = -7849;   sample_q.push_back(d);
		d.x = 0;         d.y = -7850;   sample_q.push_back(d);
		d.x = 5550;      d.y = 5550;    sample_q.push_back(d);
		d.x = -1;        d.y = 16'sh8000; sample_q.push_back(d);
		d.x = 16'h5555;  d.y = 16'shAAAA; sample_q.push_back(d);
		add_random(350);

		// long receiver hold-off while the sender keeps offering
		hold_off = 300;
		add_random(100);

		// pause until every expected word has come back
		wait_drained();

		// sweep dead-zone settings including the extremes
		settings = '{15'd0, 15'd32766, 15'd1, 15'd16384, 15'd32767, 15'd7849};
		foreach (settings[i]) begin
			write_dead_zone(settings[i]);
			d.x = 16'sh7FFF; d.y = 16'sh8000; sample_q.push_back(d);
			add_random(settings[i] >= 15'd32766 ? 40 : 150);
		end
		write_dead_zone(15'($urandom_range(0, 32767)));
		add_random(100);

		draining = 1;
		wait_drained();
		if (mismatches == 0 && corrected_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tsd_pkg.sv
rtl/tsd_sqrt.sv
rtl/tsd_div.sv
rtl/thumbstick_radial_deadzone.sv
bench/thumbstick_radial_deadzone_test.sv
